// ----- hdl/ittw_pkg.sv -----
// ----------------------------------------------------------------------------
// ittw_pkg: shared types for the idle timeout timing wheel
// Transaction payloads, action codes and controller/datapath interface.
// ----------------------------------------------------------------------------
package ittw_pkg;

  localparam logic [1:0] ACT_ARM     = 2'd0;
  localparam logic [1:0] ACT_CANCEL  = 2'd1;
  localparam logic [1:0] ACT_REFRESH = 2'd2;
  localparam logic [1:0] ACT_TICK    = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] socket_id;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic       expired_valid;
    logic [5:0] expired_id;
    logic       last;
  } out_t;

  // fill memory read address source
  typedef enum logic [1:0] {
    FSEL_ARM  = 2'd0,
    FSEL_HOME = 2'd1,
    FSEL_CUR  = 2'd2
  } fsel_t;

  typedef struct packed {
    logic  load;
    fsel_t fsel;
    logic  lat_loc;
    logic  arm_wr;
    logic  dis_a;
    logic  dis_b;
    logic  tick_first;
    logic  tick_emit;
    logic  tick_end;
    logic  emit_resp;
    logic  resp_ok;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       id_ok;
    logic       armed;
    logic       fill_zero;
    logic       tick_last;
  } sts_t;

endpackage

// ----- hdl/ittw_ctrl.sv -----
// ----------------------------------------------------------------------------
// ittw_ctrl: sequencer for the timing wheel
// Steps each transaction through the memory read-modify-write sequence.
// ----------------------------------------------------------------------------
module ittw_ctrl import ittw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DECODE   = 11'b000_0000_0010,
    S_ARM_RD   = 11'b000_0000_0100,
    S_ARM_WR   = 11'b000_0000_1000,
    S_DIS_RD   = 11'b000_0001_0000,
    S_DIS_FILL = 11'b000_0010_0000,
    S_DIS_A    = 11'b000_0100_0000,
    S_DIS_B    = 11'b000_1000_0000,
    S_TK_RD    = 11'b001_0000_0000,
    S_TK_FIRST = 11'b010_0000_0000,
    S_TK_EMIT  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   empty_r, empty_nxt;

  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    empty_nxt = 1'b0;
    cmd       = '0;
    cmd.fsel  = FSEL_ARM;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.action == ACT_TICK) begin
          state_nxt = S_TK_RD;
        end else if (!sts.id_ok) begin
          cmd.emit_resp = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.action == ACT_ARM) begin
          if (sts.armed) begin
            cmd.emit_resp = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_ARM_RD;
          end
        end else if (sts.action == ACT_CANCEL) begin
          if (sts.armed) begin
            state_nxt = S_DIS_RD;
          end else begin
            cmd.emit_resp = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          if (sts.armed) begin
            state_nxt = S_DIS_RD;
          end else begin
            state_nxt = S_ARM_RD;
          end
        end
      end
      S_ARM_RD: begin
        cmd.fsel  = FSEL_ARM;
        state_nxt = S_ARM_WR;
      end
      S_ARM_WR: begin
        cmd.arm_wr    = 1'b1;
        cmd.emit_resp = 1'b1;
        cmd.resp_ok   = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_DIS_RD: begin
        state_nxt = S_DIS_FILL;
      end
      S_DIS_FILL: begin
        cmd.fsel    = FSEL_HOME;
        cmd.lat_loc = 1'b1;
        state_nxt   = S_DIS_A;
      end
      S_DIS_A: begin
        cmd.dis_a = 1'b1;
        state_nxt = S_DIS_B;
      end
      S_DIS_B: begin
        cmd.dis_b = 1'b1;
        if (sts.action == ACT_CANCEL) begin
          cmd.emit_resp = 1'b1;
          cmd.resp_ok   = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_ARM_RD;
        end
      end
      S_TK_RD: begin
        cmd.fsel  = FSEL_CUR;
        state_nxt = S_TK_FIRST;
      end
      S_TK_FIRST: begin
        cmd.tick_first = 1'b1;
        empty_nxt      = sts.fill_zero;
        state_nxt      = S_TK_EMIT;
      end
      S_TK_EMIT: begin
        // drain one entry a cycle, or report an empty slot
        if (empty_r) begin
          cmd.emit_resp = 1'b1;
          cmd.tick_end  = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.tick_emit = 1'b1;
          if (sts.tick_last) begin
            cmd.tick_end = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      empty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      empty_r <= empty_nxt;
    end
  end

  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_resp || cmd.tick_emit) |-> busy)
    else $error("result issued while idle");
  a_start_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_DECODE))
    else $error("accepted transaction not decoded");
  a_tick_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_end |=> !busy)
    else $error("tick did not finish");

endmodule

// ----- hdl/ittw_dp.sv -----
// ----------------------------------------------------------------------------
// ittw_dp: timing wheel datapath
// Slot lists, per-id location tables, fill counts, current slot and result.
// ----------------------------------------------------------------------------
module ittw_dp import ittw_pkg::*; #(
  parameter int MAX_IDS   = 64,
  parameter int MAX_SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_t        in_data,
  input  logic       cfg_valid,
  input  logic [6:0] cfg_data,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_strobe,
  output out_t       out_data
);

  localparam int ID_W   = $clog2(MAX_IDS);
  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int FILL_W = $clog2(MAX_IDS + 1);
  localparam int LEN_W  = $clog2(MAX_SLOTS + 1);
  localparam int CW     = ((LEN_W > 7) ? LEN_W : 7) + 1;
  localparam int ENT_D  = 1 << (SLOT_W + ID_W);

  // memories
  logic [ID_W-1:0]   ent_mem  [ENT_D];
  logic [SLOT_W-1:0] home_mem [MAX_IDS];
  logic [ID_W-1:0]   pos_mem  [MAX_IDS];
  logic [FILL_W-1:0] fill_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] fill_vld_r;
  logic [MAX_IDS-1:0]   armed_r;

  logic [ID_W-1:0]   ent_q, pos_q;
  logic [SLOT_W-1:0] home_q;
  logic [FILL_W-1:0] fill_q;

  logic [1:0]        act_r;
  logic [5:0]        id_r;
  logic [6:0]        wlen_r;
  logic [SLOT_W-1:0] cur_r, slot_r;
  logic [ID_W-1:0]   pos_r, idx_r;
  logic [FILL_W-1:0] fill_r;
  logic              out_strobe_r;
  out_t              out_r, out_nxt;

  logic [ID_W-1:0]   idx;
  logic [CW-1:0]     eff_len;
  logic [SLOT_W-1:0] arm_slot, cur_next;
  logic [CW-1:0]     cur_inc;
  logic [SLOT_W-1:0] fill_raddr;
  logic [SLOT_W+ID_W-1:0] ent_raddr;
  logic [FILL_W-1:0] fill_dec;
  logic              tick_last;

  assign idx = id_r[ID_W-1:0];

  // clamp wheel length to 1..MAX_SLOTS
  always_comb begin
    if (wlen_r == 7'd0) begin
      eff_len = CW'(1);
    end else if (CW'(wlen_r) > CW'(MAX_SLOTS)) begin
      eff_len = CW'(MAX_SLOTS);
    end else begin
      eff_len = CW'(wlen_r);
    end
  end

  // arm slot sits just behind the current one
  always_comb begin
    if (cur_r != '0) begin
      arm_slot = cur_r - 1'b1;
    end else begin
      arm_slot = SLOT_W'(eff_len - 1'b1);
    end
    cur_inc  = CW'(cur_r) + 1'b1;
    cur_next = (cur_inc >= eff_len) ? '0 : SLOT_W'(cur_inc);
  end

  // fill read address
  always_comb begin
    case (cmd.fsel)
      FSEL_ARM:  fill_raddr = arm_slot;
      FSEL_HOME: fill_raddr = home_q;
      FSEL_CUR:  fill_raddr = cur_r;
      default:   fill_raddr = cur_r;
    endcase
  end

  assign fill_dec  = (fill_q == '0) ? '0 : fill_q - 1'b1;
  assign tick_last = (FILL_W'(idx_r) + 1'b1 == fill_r);

  // entry read address
  always_comb begin
    if (cmd.dis_a) begin
      ent_raddr = {slot_r, ID_W'(fill_dec)};
    end else if (cmd.tick_first) begin
      ent_raddr = {cur_r, {ID_W{1'b0}}};
    end else begin
      ent_raddr = {cur_r, idx_r + 1'b1};
    end
  end

  // memory reads
  always_ff @(posedge clk) begin
    ent_q  <= ent_mem[ent_raddr];
    home_q <= home_mem[idx];
    pos_q  <= pos_mem[idx];
    fill_q <= fill_vld_r[fill_raddr] ? fill_mem[fill_raddr] : '0;
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.arm_wr) begin
      ent_mem[{arm_slot, ID_W'(fill_q)}] <= idx;
      fill_mem[arm_slot] <= fill_q + 1'b1;
      home_mem[idx] <= arm_slot;
      pos_mem[idx]  <= ID_W'(fill_q);
    end else if (cmd.dis_a) begin
      if (fill_q != '0) begin
        fill_mem[slot_r] <= fill_dec;
      end
    end else if (cmd.dis_b) begin
      if (FILL_W'(pos_r) < fill_r) begin
        ent_mem[{slot_r, pos_r}] <= ent_q;
        pos_mem[ent_q] <= pos_r;
      end
    end
  end

  // hold transaction, location and tick counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_data.action;
      id_r  <= in_data.socket_id;
    end
    if (cmd.lat_loc) begin
      slot_r <= home_q;
      pos_r  <= pos_q;
    end
    if (cmd.dis_a) begin
      fill_r <= fill_dec;
    end
    if (cmd.tick_first) begin
      fill_r <= fill_q;
      idx_r  <= '0;
    end else if (cmd.tick_emit) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // control state: armed flags, fill valid bits, current slot, length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r    <= '0;
      fill_vld_r <= '0;
      cur_r      <= '0;
      wlen_r     <= 7'd64;
    end else begin
      if (cfg_valid) begin
        wlen_r <= cfg_data;
      end
      if (cmd.arm_wr) begin
        armed_r[idx]         <= 1'b1;
        fill_vld_r[arm_slot] <= 1'b1;
      end
      if (cmd.dis_a) begin
        armed_r[idx] <= 1'b0;
      end
      if (cmd.tick_emit) begin
        armed_r[ent_q] <= 1'b0;
      end
      if (cmd.tick_end) begin
        fill_vld_r[cur_r] <= 1'b0;
        cur_r             <= cur_next;
      end
    end
  end

  // result register
  always_comb begin
    out_nxt = '0;
    if (cmd.tick_emit) begin
      out_nxt.expired_valid = 1'b1;
      out_nxt.expired_id    = 6'(ent_q);
      out_nxt.last          = tick_last;
    end else if (cmd.emit_resp) begin
      out_nxt.accepted = cmd.resp_ok;
      out_nxt.last     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.tick_emit || cmd.emit_resp;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  assign sts.action    = act_r;
  assign sts.id_ok     = ({1'b0, id_r} < 7'(MAX_IDS));
  assign sts.armed     = armed_r[idx];
  assign sts.fill_zero = (fill_q == '0);
  assign sts.tick_last = tick_last;

endmodule

// ----- hdl/idle_timeout_timer_wheel.sv -----
// Throughput: one transaction at a time; a tick emits one expired id a cycle.
// The receiver cannot stall.
// Reset (rst_n low, synchronous) disarms all ids, empties all slots, sets the
// current slot to 0 and the wheel length to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
// idle_timeout_timer_wheel: idle timeout timing wheel
// Arms, cancels and refreshes connection timeouts and expires them on tick.
// ----------------------------------------------------------------------------
module idle_timeout_timer_wheel import ittw_pkg::*; #(
  parameter int MAX_IDS   = 64,
  parameter int MAX_SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_data,
  output logic       out_strobe,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  ittw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // storage and result path
  ittw_dp #(
    .MAX_IDS   (MAX_IDS),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
